FILE: rtl/lom_pkg.sv
// Shared types and codes for the limit order matcher.
package lom_pkg;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_TRADE,
    ST_POP,
    ST_REST,
    ST_SEARCH,
    ST_INSERT,
    ST_SUMMARY
  } state_t;

  // Commands from the sequencer to one side of the book.
  typedef struct packed {
    logic pop;      // drop head entry, shift rest towards head
    logic wr_head;  // overwrite head quantity
    logic ins;      // insert new entry at ins_pos
  } book_op_t;

  // Shared comparator / subtractor results.
  typedef struct packed {
    logic        lt;   // a < b
    logic        eq;   // a == b
    logic [31:0] mag;  // |a - b|
  } alu_res_t;

endpackage

FILE: rtl/lom_alu.sv
// Shared compare and subtract unit used by the cross, trade and search steps.
module lom_alu
  import lom_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_res_t    res
);

  logic [32:0] diff;

  assign diff    = {1'b0, a} - {1'b0, b};
  assign res.lt  = diff[32];
  assign res.eq  = (diff[31:0] == 32'd0);
  assign res.mag = diff[32] ? (32'd0 - diff[31:0]) : diff[31:0];

endmodule

FILE: rtl/lom_book.sv
// One side of the book: priority-ordered entries held as a shifting register file.
module lom_book
  import lom_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  book_op_t                   op,
  input  logic [$clog2(DEPTH)-1:0]   rd_idx,
  input  logic [$clog2(DEPTH)-1:0]   ins_pos,
  input  logic [31:0]                head_qty,
  input  logic [31:0]                ins_price,
  input  logic [31:0]                ins_qty,
  input  logic [31:0]                ins_id,
  output logic [31:0]                rd_price,
  output logic [31:0]                rd_qty,
  output logic [31:0]                rd_id,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0] price [DEPTH];
  logic [31:0] qty   [DEPTH];
  logic [31:0] id    [DEPTH];

  assign rd_price = price[rd_idx];
  assign rd_qty   = qty[rd_idx];
  assign rd_id    = id[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op.pop) begin
      count <= count - CW'(1);
    end else if (op.ins) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (op.pop) begin
        if (i < DEPTH - 1) begin
          price[i] <= price[i+1];
          qty[i]   <= qty[i+1];
          id[i]    <= id[i+1];
        end
      end else if (op.ins) begin
        if (i == int'(ins_pos)) begin
          price[i] <= ins_price;
          qty[i]   <= ins_qty;
          id[i]    <= ins_id;
        end else if (i > int'(ins_pos)) begin
          price[i] <= price[i-1];
          qty[i]   <= qty[i-1];
          id[i]    <= id[i-1];
        end
      end else if (op.wr_head && i == 0) begin
        qty[i] <= head_qty;
      end
    end
  end

endmodule

FILE: rtl/limit_order_matcher.sv
// Limit order matcher top level: sequencer, output register and both book sides.
// Sequence: the order is accepted in IDLE, then CROSS tests the price before the first fill;
// a fully filled resting order takes TRADE, POP and a new CROSS, a partial one TRADE only;
// resting takes REST, a SEARCH step per position up to BOOK_DEPTH, INSERT, then SUMMARY.
// One order at a time; each fill and the summary wait while m_tready is low.
// Reset (rst, synchronous): both sides empty, id counter zero, no result pending.
module limit_order_matcher
  import lom_pkg::*;
#(
  parameter int BOOK_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // limit_price[31:0], order_quantity[63:32]
  input  logic         s_tuser,   // side (0 buy, 1 sell)
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // fill_quantity, fill_price, maker_id,
                                  // rested_quantity, new_order_id, book_full, pad
  output logic         m_tuser,   // is_fill
  output logic         m_tlast    // last
);

  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  state_t state, state_next;

  // Request being worked on
  logic        side;
  logic [31:0] limit;
  logic [31:0] qty;
  logic [31:0] next_id;
  logic [CW-1:0] pos;
  logic        full;
  logic [31:0] rested;
  logic [31:0] nid;

  // Result register
  logic [31:0] r_fqty, r_fprice, r_maker, r_rested, r_nid;
  logic        r_full, r_fill, r_last;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // Book sides
  book_op_t    ask_op, bid_op, match_op, own_op;
  logic [IW-1:0] ask_idx, bid_idx;
  logic [31:0] ask_p, ask_q, ask_i, bid_p, bid_q, bid_i;
  logic [CW-1:0] ask_cnt, bid_cnt;
  logic [31:0] head_qty;

  // Opposite side (matched) and own side (rest) views
  logic [31:0]   m_p, m_q, m_i, o_p;
  logic [CW-1:0] m_cnt, o_cnt;
  logic          buy;

  assign buy   = (side == SIDE_BUY);
  assign m_p   = buy ? ask_p : bid_p;
  assign m_q   = buy ? ask_q : bid_q;
  assign m_i   = buy ? ask_i : bid_i;
  assign m_cnt = buy ? ask_cnt : bid_cnt;
  assign o_p   = buy ? bid_p : ask_p;
  assign o_cnt = buy ? bid_cnt : ask_cnt;

  // Own side is read at the search position, the matched side at its head.
  assign ask_idx = buy ? '0 : pos[IW-1:0];
  assign bid_idx = buy ? pos[IW-1:0] : '0;
  assign ask_op  = buy ? match_op : own_op;
  assign bid_op  = buy ? own_op : match_op;

  // Shared unit
  logic [31:0] alu_a, alu_b;
  alu_res_t    alu;

  lom_alu u_alu (.a(alu_a), .b(alu_b), .res(alu));

  lom_book #(.DEPTH(BOOK_DEPTH)) u_ask (
    .clk, .rst, .op(ask_op), .rd_idx(ask_idx), .ins_pos(pos[IW-1:0]),
    .head_qty, .ins_price(limit), .ins_qty(qty), .ins_id(next_id + 32'd1),
    .rd_price(ask_p), .rd_qty(ask_q), .rd_id(ask_i), .count(ask_cnt)
  );

  lom_book #(.DEPTH(BOOK_DEPTH)) u_bid (
    .clk, .rst, .op(bid_op), .rd_idx(bid_idx), .ins_pos(pos[IW-1:0]),
    .head_qty, .ins_price(limit), .ins_qty(qty), .ins_id(next_id + 32'd1),
    .rd_price(bid_p), .rd_qty(bid_q), .rd_id(bid_i), .count(bid_cnt)
  );

  // Operand select: price cross test, quantity trade, insert search
  always_comb begin
    alu_a = m_q;
    alu_b = qty;
    unique case (state)
      ST_CROSS: begin
        alu_a = buy ? limit : m_p;
        alu_b = buy ? m_p : limit;
      end
      ST_SEARCH: begin
        alu_a = buy ? o_p : limit;
        alu_b = buy ? limit : o_p;
      end
      default: begin
        alu_a = m_q;
        alu_b = qty;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_CROSS;
      ST_CROSS: begin
        if (qty == 32'd0 || m_cnt == '0 || alu.lt) state_next = ST_REST;
        else state_next = ST_TRADE;
      end
      ST_TRADE: begin
        if (out_free) begin
          if (alu.lt || alu.eq) state_next = ST_POP;
          else state_next = ST_REST;
        end
      end
      ST_POP:    state_next = ST_CROSS;
      ST_REST: begin
        if (qty == 32'd0 || o_cnt == CW'(BOOK_DEPTH)) state_next = ST_SUMMARY;
        else state_next = ST_SEARCH;
      end
      ST_SEARCH: if (pos == o_cnt || alu.lt) state_next = ST_INSERT;
      ST_INSERT: state_next = ST_SUMMARY;
      ST_SUMMARY: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Book commands
  always_comb begin
    match_op = '0;
    own_op   = '0;
    head_qty = alu.mag;
    unique case (state)
      ST_TRADE:  match_op.wr_head = out_free && !alu.lt && !alu.eq;
      ST_POP:    match_op.pop = 1'b1;
      ST_INSERT: own_op.ins = 1'b1;
      default: begin
        match_op = '0;
        own_op   = '0;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      next_id <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INSERT) next_id <= next_id + 32'd1;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        side   <= s_tuser;
        limit  <= s_tdata[31:0];
        qty    <= s_tdata[63:32];
        full   <= 1'b0;
        rested <= '0;
        nid    <= '0;
      end
      ST_TRADE: if (out_free) qty <= alu.lt ? alu.mag : 32'd0;
      ST_REST: begin
        pos  <= '0;
        full <= (qty != 32'd0) && (o_cnt == CW'(BOOK_DEPTH));
      end
      ST_SEARCH: if (pos != o_cnt && !alu.lt) pos <= pos + CW'(1);
      ST_INSERT: begin
        rested <= qty;
        nid    <= next_id + 32'd1;
      end
      default: begin
      end
    endcase
  end

  // Result register: fills and the closing summary
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_TRADE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (state == ST_SUMMARY && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_TRADE && out_free) begin
      r_fill   <= 1'b1;
      r_fqty   <= alu.lt ? m_q : qty;
      r_fprice <= m_p;
      r_maker  <= m_i;
      r_rested <= '0;
      r_nid    <= '0;
      r_full   <= 1'b0;
      r_last   <= 1'b0;
    end else if (state == ST_SUMMARY && out_free) begin
      r_fill   <= 1'b0;
      r_fqty   <= '0;
      r_fprice <= '0;
      r_maker  <= '0;
      r_rested <= rested;
      r_nid    <= nid;
      r_full   <= full;
      r_last   <= 1'b1;
    end
  end

  assign m_tdata = {7'd0, r_full, r_nid, r_rested, r_maker, r_fprice, r_fqty};
  assign m_tuser = r_fill;
  assign m_tlast = r_last;

endmodule

FILE: tb/limit_order_matcher_checker.sv
// Checker for the limit order matcher: book predictor and result comparison.
`timescale 1ns / 1ps
module limit_order_matcher_checker
  import lom_pkg::*;
#(
  parameter int BOOK_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [167:0] m_tdata,
  input  logic         m_tuser,
  input  logic         m_tlast,
  output int           errors,
  output int           pending,
  output int           fills_seen,
  output int           rests_seen,
  output int           drops_seen
);

  typedef struct packed {
    logic        is_fill;
    logic [31:0] qty;
    logic [31:0] price;
    logic [31:0] maker;
    logic [31:0] rested;
    logic [31:0] nid;
    logic        full;
    logic        last;
  } trade_rpt_t;

  // own copy of the book: index 0 is the best price on each side
  logic [31:0] ask_px[$], ask_qty[$], ask_id[$];
  logic [31:0] bid_px[$], bid_qty[$], bid_id[$];
  logic [31:0] id_ctr;
  trade_rpt_t  due_rpts[$];

  function automatic trade_rpt_t mk_rpt(logic f, logic [31:0] q, logic [31:0] p,
                                        logic [31:0] m, logic [31:0] r,
                                        logic [31:0] n, logic fl);
    trade_rpt_t t;
    t = '{f, q, p, m, r, n, fl, !f};
    return t;
  endfunction

  task automatic match_order(logic side, logic [31:0] lim, logic [31:0] qty);
    logic        is_buy;
    logic [31:0] take, rest_n, nid;
    logic        full;
    int          pos;
    is_buy = (side == SIDE_BUY);
    rest_n = 0; nid = 0; full = 0;
    if (is_buy) begin
      while (qty != 0 && ask_px.size() > 0 && !(lim < ask_px[0])) begin
        take = (ask_qty[0] < qty) ? ask_qty[0] : qty;
        ask_qty[0] -= take;
        qty -= take;
        due_rpts.push_back(mk_rpt(1, take, ask_px[0], ask_id[0], 0, 0, 0));
        if (ask_qty[0] != 0) break;
        void'(ask_px.pop_front()); void'(ask_qty.pop_front()); void'(ask_id.pop_front());
      end
    end else begin
      while (qty != 0 && bid_px.size() > 0 && !(lim > bid_px[0])) begin
        take = (bid_qty[0] < qty) ? bid_qty[0] : qty;
        bid_qty[0] -= take;
        qty -= take;
        due_rpts.push_back(mk_rpt(1, take, bid_px[0], bid_id[0], 0, 0, 0));
        if (bid_qty[0] != 0) break;
        void'(bid_px.pop_front()); void'(bid_qty.pop_front()); void'(bid_id.pop_front());
      end
    end
    if (qty != 0) begin
      if (is_buy) begin
        if (bid_px.size() >= BOOK_DEPTH) full = 1;
        else begin
          pos = 0;
          while (pos < bid_px.size() && !(bid_px[pos] < lim)) pos++;
          id_ctr += 1;
          bid_px.insert(pos, lim); bid_qty.insert(pos, qty); bid_id.insert(pos, id_ctr);
          rest_n = qty; nid = id_ctr;
        end
      end else begin
        if (ask_px.size() >= BOOK_DEPTH) full = 1;
        else begin
          pos = 0;
          while (pos < ask_px.size() && !(ask_px[pos] > lim)) pos++;
          id_ctr += 1;
          ask_px.insert(pos, lim); ask_qty.insert(pos, qty); ask_id.insert(pos, id_ctr);
          rest_n = qty; nid = id_ctr;
        end
      end
    end
    due_rpts.push_back(mk_rpt(0, 0, 0, 0, rest_n, nid, full));
  endtask

  task automatic cmp(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    trade_rpt_t e;
    if (rst) begin
      ask_px.delete(); ask_qty.delete(); ask_id.delete();
      bid_px.delete(); bid_qty.delete(); bid_id.delete();
      due_rpts.delete();
      id_ctr = 0; errors = 0; fills_seen = 0; rests_seen = 0; drops_seen = 0;
    end else begin
      if (s_tvalid && s_tready) match_order(s_tuser, s_tdata[31:0], s_tdata[63:32]);
      if (m_tvalid && m_tready) begin
        if (due_rpts.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = due_rpts.pop_front();
          cmp("is_fill", 32'(e.is_fill), 32'(m_tuser));
          cmp("fill_quantity", e.qty, m_tdata[31:0]);
          cmp("fill_price", e.price, m_tdata[63:32]);
          cmp("maker_id", e.maker, m_tdata[95:64]);
          cmp("rested_quantity", e.rested, m_tdata[127:96]);
          cmp("new_order_id", e.nid, m_tdata[159:128]);
          cmp("book_full", 32'(e.full), 32'(m_tdata[160]));
          cmp("last", 32'(e.last), 32'(m_tlast));
          if (e.is_fill) fills_seen++;
          if (e.nid != 0) rests_seen++;
          if (e.full) drops_seen++;
        end
      end
    end
    pending = due_rpts.size();
  end

endmodule

FILE: tb/limit_order_matcher_tb.sv
// Top of the limit order matcher testbench: clock, reset, order stimulus, verdict.
`timescale 1ns / 1ps
module limit_order_matcher_tb;
  import lom_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 1500000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // limit_price[31:0], order_quantity[63:32]
  logic         s_tuser = 0;    // side
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [167:0] m_tdata;        // fill_quantity .. book_full, pad
  logic         m_tuser;        // is_fill
  logic         m_tlast;
  int           errors, pending, fills_seen, rests_seen, drops_seen;
  int           cycles = 0;
  int           orders_sent = 0;
  bit           hold_sink = 0;  // long receiver stall already taken

  always #5 clk = ~clk;

  limit_order_matcher #(.BOOK_DEPTH(DEPTH)) dut (.*);

  limit_order_matcher_checker #(.BOOK_DEPTH(DEPTH)) chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("limit_order_matcher_tb: done, errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, one long hold-off, then a calm stretch
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if (!hold_sink && orders_sent >= 60) begin
        hold_sink = 1;
        m_tready <= 0;
        repeat (300) @(negedge clk);
      end else if (orders_sent > 60 && orders_sent < 90) m_tready <= 1;
      else begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 0;
          repeat (g) @(negedge clk);
        end
        m_tready <= 1;
      end
      @(negedge clk);
    end
  end

  // one request: hold tvalid until accepted at a rising edge
  task automatic send_order(logic side, logic [31:0] px, logic [31:0] qty);
    s_tuser  <= side;
    s_tdata  <= {qty, px};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    orders_sent++;
    if (orders_sent < 60 || orders_sent > 90) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        s_tvalid <= 0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);
  endtask

  initial begin
    int i, kind;
    logic [31:0] px, q;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: zero quantity, extremes, resting, crossing, sweeps
    send_order(SIDE_BUY, 32'd100, 32'd0);
    send_order(SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(SIDE_BUY, 32'd0, 32'hFFFF_FFFF);
    send_order(SIDE_BUY, 32'hFFFF_FFFF, 32'd1);        // partial fill of top ask
    send_order(SIDE_SELL, 32'd0, 32'd5);               // partial fill of bid at 0
    send_order(SIDE_SELL, 32'd50, 32'd3);
    send_order(SIDE_SELL, 32'd50, 32'd4);              // same price, queued behind
    send_order(SIDE_SELL, 32'd40, 32'd2);
    send_order(SIDE_BUY, 32'd50, 32'd6);               // crosses two levels
    send_order(SIDE_BUY, 32'd49, 32'd9);               // does not cross, rests
    send_order(SIDE_SELL, 32'd10, 32'hFFFF_FFFF);      // takes bids down to 10, remainder rests
    drain();

    // fill the bid side to overflow
    for (i = 0; i < DEPTH + 2; i++)
      send_order(SIDE_BUY, $urandom_range(1, 8), $urandom_range(1, 20));
    // sweep the bid side with one large sell
    send_order(SIDE_SELL, 32'd0, 32'hFFFF_FFFF);
    drain();

    // random orders near a mid price, occasional extremes
    for (i = 0; i < 110; i++) begin
      if (i == 100) drain();
      kind = $urandom_range(0, 19);
      px = 32'd1000 + $urandom_range(0, 20) - 10;
      q  = $urandom_range(1, 50);
      if (kind == 0) q = 0;
      else if (kind == 1) q = $urandom;
      else if (kind == 2) px = $urandom;
      else if (kind == 3) px = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      send_order(1'($urandom_range(0, 1)), px, q);
    end
    drain();

    $display("%0d orders, %0d fills, %0d rested, %0d dropped on a full side",
             orders_sent, fills_seen, rests_seen, drops_seen);
    if (errors == 0) $display("limit_order_matcher_tb: done, clean");
    else $display("limit_order_matcher_tb: done, errors");
    $finish;
  end

endmodule
